// File: hw/rtl/stack_vm_execute_unit_top_assert.svh
// assertion macros used by the checker file
`ifndef STACK_VM_EXECUTE_UNIT_TOP_ASSERT_SVH
`define STACK_VM_EXECUTE_UNIT_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SVX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define SVX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/svx_pkg.sv
// ----------------------------------------------------------------------------
// svx_pkg
// constants, opcodes and status codes of the stack machine execute unit
// ----------------------------------------------------------------------------
package svx_pkg;
    localparam int STACK_DEPTH = 256;
    localparam int HEAP_WORDS  = 1024;
    localparam int CALL_DEPTH  = 64;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int HA_W  = $clog2(HEAP_WORDS);
    localparam int RP_W  = $clog2(CALL_DEPTH);

    localparam logic [4:0] OP_PUSH = 5'd0,  OP_DUP = 5'd1,  OP_COPY = 5'd2;
    localparam logic [4:0] OP_SWAP = 5'd3,  OP_DROP = 5'd4, OP_SLIDE = 5'd5;
    localparam logic [4:0] OP_ADD = 5'd6,   OP_SUB = 5'd7,  OP_MUL = 5'd8;
    localparam logic [4:0] OP_DIV = 5'd9,   OP_MOD = 5'd10, OP_STORE = 5'd11;
    localparam logic [4:0] OP_RETR = 5'd12, OP_LABEL = 5'd13, OP_CALL = 5'd14;
    localparam logic [4:0] OP_JUMP = 5'd15, OP_JZ = 5'd16,  OP_JNEG = 5'd17;
    localparam logic [4:0] OP_RET = 5'd18,  OP_END = 5'd19, OP_OUTC = 5'd20;
    localparam logic [4:0] OP_OUTN = 5'd21, OP_READC = 5'd22, OP_READN = 5'd23;

    localparam logic [2:0] ST_OK = 3'd0, ST_JUMP = 3'd1, ST_EXIT = 3'd2;
    localparam logic [2:0] ST_UNDER = 3'd3, ST_HEAP = 3'd4, ST_DIV0 = 3'd5;
    localparam logic [2:0] ST_OVER = 3'd6, ST_HALT = 3'd7;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;      // capture instruction
        logic       rd_a;      // read top entry
        logic       rd_b;      // read second entry / indexed entry
        logic       rd_heap;   // read heap at top value
        logic       rd_ret;    // read return stack
        logic       div_start;
        logic       mul_go;    // register product
        logic       commit;    // apply results, build output word
        logic       clr_step;  // heap clear sweep step
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic       div_busy;
        logic       clr_done;
    } t_stat;
endpackage

// File: hw/rtl/svx_divider.sv
// ----------------------------------------------------------------------------
// svx_divider
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svx_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, n_q, r_r, n_r, r_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;

    // one shift-subtract step
    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy;
        w_trial = {r_r, r_q[31]} - {1'b0, r_d};
        if (i_start) begin
            n_q = i_dividend; n_r = '0; n_cnt = 6'd32; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) n_r = w_trial[31:0];
            else n_r = {r_r[30:0], r_q[31]};
            n_q = {r_q[30:0], ~w_trial[32]};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) r_d <= i_divisor;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// File: hw/rtl/svx_datapath.sv
// ----------------------------------------------------------------------------
// svx_datapath
// stacks, heap, arithmetic and result formation
// ----------------------------------------------------------------------------
module svx_datapath (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  svx_pkg::t_cmd i_cmd,
    output svx_pkg::t_stat o_stat,
    input  logic [4:0]  i_op,
    input  logic [31:0] i_imm,
    input  logic [15:0] i_target,
    input  logic [15:0] i_fall,
    input  logic [31:0] i_rd,
    output logic [52:0] o_word
);
    logic [31:0] r_dstk [svx_pkg::STACK_DEPTH];
    logic [31:0] r_heap [svx_pkg::HEAP_WORDS];
    logic [15:0] r_rstk [svx_pkg::CALL_DEPTH];

    logic [4:0]  r_op;
    logic [31:0] r_imm, r_rd, r_a, r_b, r_hv, r_prod;
    logic [15:0] r_tgt, r_fall, r_rv;
    logic [svx_pkg::SP_W:0] r_sp;
    logic [svx_pkg::RP_W:0] r_rp;
    logic        r_run;
    logic [svx_pkg::HA_W:0] r_clr;
    logic [52:0] r_word;

    logic [svx_pkg::SP_W:0] w_idx;
    logic [31:0] w_ma, w_mb, w_q, w_rem;
    logic        w_busy;
    logic        w_div_op;

    // operand b index: second entry, or copy index below top
    always_comb begin
        if (r_op == svx_pkg::OP_COPY)
            w_idx = r_sp - 1'b1 - r_imm[svx_pkg::SP_W:0];
        else
            w_idx = r_sp - 2'd2;
    end

    assign w_ma = r_b[31] ? 32'd0 - r_b : r_b;
    assign w_mb = r_a[31] ? 32'd0 - r_a : r_a;

    // divider only runs for div and mod
    assign w_div_op = (r_op == svx_pkg::OP_DIV) || (r_op == svx_pkg::OP_MOD);

    svx_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start && w_div_op),
        .i_dividend(w_ma), .i_divisor(w_mb), .o_busy(w_busy),
        .o_quot(w_q), .o_rem(w_rem)
    );

    assign o_stat.div_busy = w_busy;
    assign o_stat.clr_done = r_clr[svx_pkg::HA_W];
    assign o_word = r_word;

    // operand capture and memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_imm <= i_imm; r_tgt <= i_target;
            r_fall <= i_fall; r_rd <= i_rd;
        end
        if (i_cmd.rd_a) r_a <= r_dstk[r_sp[svx_pkg::SP_W-1:0] - 1'b1];
        if (i_cmd.rd_b) r_b <= r_dstk[w_idx[svx_pkg::SP_W-1:0]];
        if (i_cmd.rd_heap) r_hv <= r_heap[r_a[svx_pkg::HA_W-1:0]];
        if (i_cmd.rd_ret) r_rv <= r_rstk[r_rp[svx_pkg::RP_W-1:0] - 1'b1];
        if (i_cmd.mul_go) r_prod <= r_a * r_b;
    end

    // execute and commit
    logic [2:0]  w_st;
    logic [15:0] w_pc;
    logic [1:0]  w_kind;
    logic [31:0] w_oval, w_res;
    logic        w_hok, w_hok_b, w_neg_i, w_i_lt;
    always_comb begin
        w_st = svx_pkg::ST_OK; w_pc = r_fall; w_kind = 2'd0; w_oval = '0;
        w_res = '0;
        w_hok   = !r_a[31] && (r_a < 32'(svx_pkg::HEAP_WORDS));
        w_hok_b = !r_b[31] && (r_b < 32'(svx_pkg::HEAP_WORDS));
        w_neg_i = r_imm[31];
        w_i_lt  = r_imm < 32'(r_sp);
        if (!r_run) w_st = svx_pkg::ST_HALT;
        else begin
            case (r_op)
                svx_pkg::OP_PUSH:
                    if (r_sp >= (svx_pkg::SP_W+1)'(svx_pkg::STACK_DEPTH)) w_st = svx_pkg::ST_OVER;
                svx_pkg::OP_DUP:
                    if (r_sp < 1) w_st = svx_pkg::ST_UNDER;
                    else if (r_sp >= (svx_pkg::SP_W+1)'(svx_pkg::STACK_DEPTH))
                        w_st = svx_pkg::ST_OVER;
                svx_pkg::OP_COPY:
                    if (w_neg_i || !w_i_lt) w_st = svx_pkg::ST_UNDER;
                    else if (r_sp >= (svx_pkg::SP_W+1)'(svx_pkg::STACK_DEPTH))
                        w_st = svx_pkg::ST_OVER;
                svx_pkg::OP_SWAP: if (r_sp < 2) w_st = svx_pkg::ST_UNDER;
                svx_pkg::OP_DROP: if (r_sp < 1) w_st = svx_pkg::ST_UNDER;
                svx_pkg::OP_SLIDE: if (w_neg_i || !w_i_lt) w_st = svx_pkg::ST_UNDER;
                svx_pkg::OP_ADD, svx_pkg::OP_SUB, svx_pkg::OP_MUL: begin
                    if (r_sp < 2) w_st = svx_pkg::ST_UNDER;
                end
                svx_pkg::OP_DIV, svx_pkg::OP_MOD: begin
                    if (r_sp < 2) w_st = svx_pkg::ST_UNDER;
                    else if (r_a == 32'd0) w_st = svx_pkg::ST_DIV0;
                end
                svx_pkg::OP_STORE:
                    if (r_sp < 2) w_st = svx_pkg::ST_UNDER;
                    else if (!w_hok_b) w_st = svx_pkg::ST_HEAP;
                svx_pkg::OP_RETR, svx_pkg::OP_READC, svx_pkg::OP_READN:
                    if (r_sp < 1) w_st = svx_pkg::ST_UNDER;
                    else if (!w_hok) w_st = svx_pkg::ST_HEAP;
                svx_pkg::OP_CALL:
                    if (r_rp >= (svx_pkg::RP_W+1)'(svx_pkg::CALL_DEPTH)) w_st = svx_pkg::ST_OVER;
                    else begin w_st = svx_pkg::ST_JUMP; w_pc = r_tgt; end
                svx_pkg::OP_JUMP: begin w_st = svx_pkg::ST_JUMP; w_pc = r_tgt; end
                svx_pkg::OP_JZ, svx_pkg::OP_JNEG:
                    if (r_sp < 1) w_st = svx_pkg::ST_UNDER;
                    else if ((r_op == svx_pkg::OP_JZ && r_a == 32'd0) ||
                             (r_op == svx_pkg::OP_JNEG && r_a[31])) begin
                        w_st = svx_pkg::ST_JUMP; w_pc = r_tgt;
                    end
                svx_pkg::OP_RET:
                    if (r_rp < 1) w_st = svx_pkg::ST_UNDER;
                    else begin w_st = svx_pkg::ST_JUMP; w_pc = r_rv; end
                svx_pkg::OP_END: w_st = svx_pkg::ST_EXIT;
                svx_pkg::OP_OUTC, svx_pkg::OP_OUTN:
                    if (r_sp < 1) w_st = svx_pkg::ST_UNDER;
                    else begin
                        w_oval = r_a;
                        w_kind = (r_op == svx_pkg::OP_OUTC) ? 2'd1 : 2'd2;
                    end
                default: w_st = svx_pkg::ST_OK;
            endcase
        end
        case (r_op)
            svx_pkg::OP_ADD: w_res = r_b + r_a;
            svx_pkg::OP_SUB: w_res = r_b - r_a;
            svx_pkg::OP_MUL: w_res = r_prod;
            svx_pkg::OP_DIV: w_res = (r_b[31] != r_a[31]) ? 32'd0 - w_q : w_q;
            svx_pkg::OP_MOD: w_res = r_b[31] ? 32'd0 - w_rem : w_rem;
            default: w_res = '0;
        endcase
    end

    logic w_ok;
    assign w_ok = (w_st == svx_pkg::ST_OK) || (w_st == svx_pkg::ST_JUMP);

    // state update; only one data-stack write per commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_rp <= '0; r_run <= 1'b1; r_clr <= '0;
        end else begin
            if (i_cmd.clr_step && !r_clr[svx_pkg::HA_W]) r_clr <= r_clr + 1'b1;
            if (i_cmd.commit) begin
                if (w_st == svx_pkg::ST_EXIT || (!w_ok && w_st != svx_pkg::ST_HALT))
                    r_run <= 1'b0;
                if (w_ok) begin
                    case (r_op)
                        svx_pkg::OP_PUSH, svx_pkg::OP_DUP, svx_pkg::OP_COPY:
                            r_sp <= r_sp + 1'b1;
                        svx_pkg::OP_DROP, svx_pkg::OP_JZ, svx_pkg::OP_JNEG,
                        svx_pkg::OP_OUTC, svx_pkg::OP_OUTN, svx_pkg::OP_READC,
                        svx_pkg::OP_READN, svx_pkg::OP_ADD, svx_pkg::OP_SUB,
                        svx_pkg::OP_MUL, svx_pkg::OP_DIV, svx_pkg::OP_MOD:
                            r_sp <= r_sp - 1'b1;
                        svx_pkg::OP_STORE: r_sp <= r_sp - 2'd2;
                        svx_pkg::OP_SLIDE: r_sp <= r_sp - r_imm[svx_pkg::SP_W:0];
                        svx_pkg::OP_CALL: r_rp <= r_rp + 1'b1;
                        svx_pkg::OP_RET: r_rp <= r_rp - 1'b1;
                        default: r_sp <= r_sp;
                    endcase
                end
            end
        end
        if (i_cmd.commit) r_word <= {w_oval, w_kind, w_pc, w_st};
    end

    // stack and heap writes
    logic [svx_pkg::SP_W-1:0] w_top, w_sec;
    assign w_top = r_sp[svx_pkg::SP_W-1:0] - 1'b1;
    assign w_sec = r_sp[svx_pkg::SP_W-1:0] - 2'd2;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_ok) begin
            case (r_op)
                svx_pkg::OP_PUSH: r_dstk[r_sp[svx_pkg::SP_W-1:0]] <= r_imm;
                svx_pkg::OP_DUP:  r_dstk[r_sp[svx_pkg::SP_W-1:0]] <= r_a;
                svx_pkg::OP_COPY: r_dstk[r_sp[svx_pkg::SP_W-1:0]] <= r_b;
                svx_pkg::OP_SWAP: r_dstk[w_top] <= r_b;
                svx_pkg::OP_SLIDE:
                    r_dstk[r_sp[svx_pkg::SP_W-1:0] - r_imm[svx_pkg::SP_W-1:0] - 1'b1] <= r_a;
                svx_pkg::OP_ADD, svx_pkg::OP_SUB, svx_pkg::OP_MUL,
                svx_pkg::OP_DIV, svx_pkg::OP_MOD: r_dstk[w_sec] <= w_res;
                svx_pkg::OP_RETR: r_dstk[w_top] <= r_hv;
                default: ;
            endcase
        end
        // swap second half written before commit, in the rd_heap slot
        if (i_cmd.rd_heap && r_op == svx_pkg::OP_SWAP && r_run && r_sp >= 2)
            r_dstk[w_sec] <= r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr[svx_pkg::HA_W]) r_heap[r_clr[svx_pkg::HA_W-1:0]] <= '0;
        else if (i_cmd.commit && w_ok) begin
            if (r_op == svx_pkg::OP_STORE) r_heap[r_b[svx_pkg::HA_W-1:0]] <= r_a;
            else if (r_op == svx_pkg::OP_READC || r_op == svx_pkg::OP_READN)
                r_heap[r_a[svx_pkg::HA_W-1:0]] <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_ok && r_op == svx_pkg::OP_CALL)
            r_rstk[r_rp[svx_pkg::RP_W-1:0]] <= r_fall;
    end
endmodule

// File: hw/rtl/svx_ctrl.sv
// ----------------------------------------------------------------------------
// svx_ctrl
// sequencer: clear heap after reset, read operands, run arithmetic, commit, hand off result word
// ----------------------------------------------------------------------------
module svx_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  svx_pkg::t_stat i_stat,
    output svx_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_RD1 = 3'd2;
    localparam logic [2:0] S_RD2 = 3'd3, S_EXEC = 3'd4, S_WAIT = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ov, n_ov;

    // next-state and commands
    always_comb begin
        n_state = r_state; n_ov = r_ov;
        o_cmd = '0;
        o_cmd.clr_step = (r_state == S_CLEAR);
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_state)
            S_CLEAR: if (i_stat.clr_done) n_state = S_IDLE;
            S_IDLE: if (i_in_valid) begin o_cmd.load = 1'b1; n_state = S_RD1; end
            S_RD1: begin o_cmd.rd_a = 1'b1; o_cmd.rd_b = 1'b1; o_cmd.rd_ret = 1'b1;
                n_state = S_RD2; end
            S_RD2: begin o_cmd.rd_heap = 1'b1; o_cmd.mul_go = 1'b1; n_state = S_EXEC; end
            S_EXEC: begin o_cmd.div_start = 1'b1; n_state = S_WAIT; end
            S_WAIT: if (!i_stat.div_busy) n_state = S_COMMIT;
            S_COMMIT: if (!r_ov || i_out_ready) begin
                o_cmd.commit = 1'b1; n_ov = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_ov <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
endmodule

// File: hw/rtl/stack_vm_execute_unit_top.sv
// steps: load, operand reads, heap read and product, divider start, divider wait, commit
// one instruction at a time; div and mod also wait out the 32-step divider
// result word sits in an output register; next item may enter while it waits
// reset: synchronous active low; heap then cleared word by word, no input taken
// ----------------------------------------------------------------------------
// stack_vm_execute_unit_top
// execute unit of a stack machine with data stack, heap and call stack
// ----------------------------------------------------------------------------
module stack_vm_execute_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [103:0] s_axis_tdata, // op, immediate, target, fall_through, read_value, pad
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [55:0] m_axis_tdata   // status, next_pc, out_kind, out_value, pad
);
    svx_pkg::t_cmd  w_cmd;
    svx_pkg::t_stat w_stat;
    logic [52:0]    w_word;

    svx_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    svx_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_op(s_axis_tdata[4:0]), .i_imm(s_axis_tdata[36:5]),
        .i_target(s_axis_tdata[52:37]), .i_fall(s_axis_tdata[68:53]),
        .i_rd(s_axis_tdata[100:69]), .o_word(w_word)
    );

    assign m_axis_tdata = {3'd0, w_word};
endmodule

// File: hw/rtl/svx_checker.sv
// ----------------------------------------------------------------------------
// svx_checker
// port-level checks of the execute unit
// ----------------------------------------------------------------------------
`include "stack_vm_execute_unit_top_assert.svh"
module svx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `SVX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SVX_ASSERT_NEXT(a_no_back, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SVX_ASSERT_IMPL(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[55:53] == 3'd0)
    `SVX_ASSERT_IMPL(a_kind, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[20:19] != 2'd3)
endmodule

bind stack_vm_execute_unit_top svx_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// File: bench/tb_stack_vm_execute_unit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_vm_execute_unit_top
// streams decoded stack machine instructions into the execute unit and checks
// every result word against a behavioral machine kept in the bench; covers all
// operations, division corner cases, call/return nesting, heap traffic, one
// fault or end that stops the machine, and the halted state afterwards
// ----------------------------------------------------------------------------
module tb_stack_vm_execute_unit_top;

    typedef struct {
        logic [4:0]  op;
        logic [31:0] imm;
        logic [15:0] tgt;
        logic [15:0] fall;
        logic [31:0] rdv;
    } t_instr;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] next_pc;
        logic [1:0]  kind;
        logic [31:0] value;
    } t_outcome;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tready;
    logic         m_axis_tvalid;
    logic [55:0]  m_axis_tdata;

    stack_vm_execute_unit_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

    // machine state as the bench sees it
    logic [31:0] vm_stack [svx_pkg::STACK_DEPTH];
    int          vm_sp;
    logic [31:0] vm_heap [svx_pkg::HEAP_WORDS];
    logic [15:0] vm_calls [svx_pkg::CALL_DEPTH];
    int          vm_rp;
    bit          vm_running;

    t_outcome    pending_q[$];
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          error_count;
    int          words_sent;
    int          words_checked;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

    function automatic bit heap_addr_ok(logic [31:0] a);
        return !a[31] && a < svx_pkg::HEAP_WORDS;
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    // execute one instruction on the bench machine
    function automatic t_outcome execute_instr(t_instr x);
        t_outcome    o;
        logic [31:0] a, b, r;
        o.status  = svx_pkg::ST_OK;
        o.next_pc = x.fall;
        o.kind    = 2'd0;
        o.value   = 32'd0;
        if (!vm_running) begin
            o.status = svx_pkg::ST_HALT;
            return o;
        end
        case (x.op)
            svx_pkg::OP_PUSH, svx_pkg::OP_DUP, svx_pkg::OP_COPY: begin
                if (x.op == svx_pkg::OP_DUP && vm_sp < 1) o.status = svx_pkg::ST_UNDER;
                else if (x.op == svx_pkg::OP_COPY && (x.imm[31] || x.imm >= vm_sp))
                    o.status = svx_pkg::ST_UNDER;
                else if (vm_sp >= svx_pkg::STACK_DEPTH) o.status = svx_pkg::ST_OVER;
                else begin
                    if (x.op == svx_pkg::OP_PUSH) r = x.imm;
                    else if (x.op == svx_pkg::OP_DUP) r = vm_stack[vm_sp-1];
                    else r = vm_stack[vm_sp-1-int'(x.imm)];
                    vm_stack[vm_sp] = r;
                    vm_sp++;
                end
            end
            svx_pkg::OP_SWAP: begin
                if (vm_sp < 2) o.status = svx_pkg::ST_UNDER;
                else begin
                    a = vm_stack[vm_sp-1];
                    vm_stack[vm_sp-1] = vm_stack[vm_sp-2];
                    vm_stack[vm_sp-2] = a;
                end
            end
            svx_pkg::OP_DROP: begin
                if (vm_sp < 1) o.status = svx_pkg::ST_UNDER;
                else vm_sp--;
            end
            svx_pkg::OP_SLIDE: begin
                if (x.imm[31] || x.imm >= vm_sp) o.status = svx_pkg::ST_UNDER;
                else begin
                    a = vm_stack[vm_sp-1];
                    vm_sp -= int'(x.imm);
                    vm_stack[vm_sp-1] = a;
                end
            end
            svx_pkg::OP_ADD, svx_pkg::OP_SUB, svx_pkg::OP_MUL,
            svx_pkg::OP_DIV, svx_pkg::OP_MOD: begin
                if (vm_sp < 2) o.status = svx_pkg::ST_UNDER;
                else begin
                    b = vm_stack[vm_sp-1];
                    a = vm_stack[vm_sp-2];
                    if ((x.op == svx_pkg::OP_DIV || x.op == svx_pkg::OP_MOD) && b == 32'd0)
                        o.status = svx_pkg::ST_DIV0;
                    else begin
                        case (x.op)
                            svx_pkg::OP_ADD: r = a + b;
                            svx_pkg::OP_SUB: r = a - b;
                            svx_pkg::OP_MUL: r = a * b;
                            svx_pkg::OP_DIV: begin
                                r = abs32(a) / abs32(b);
                                if (a[31] != b[31]) r = 32'd0 - r;
                            end
                            default: begin
                                r = abs32(a) % abs32(b);
                                if (a[31]) r = 32'd0 - r;
                            end
                        endcase
                        vm_sp--;
                        vm_stack[vm_sp-1] = r;
                    end
                end
            end
            svx_pkg::OP_STORE: begin
                if (vm_sp < 2) o.status = svx_pkg::ST_UNDER;
                else if (!heap_addr_ok(vm_stack[vm_sp-2])) o.status = svx_pkg::ST_HEAP;
                else begin
                    vm_heap[vm_stack[vm_sp-2][svx_pkg::HA_W-1:0]] = vm_stack[vm_sp-1];
                    vm_sp -= 2;
                end
            end
            svx_pkg::OP_RETR: begin
                if (vm_sp < 1) o.status = svx_pkg::ST_UNDER;
                else if (!heap_addr_ok(vm_stack[vm_sp-1])) o.status = svx_pkg::ST_HEAP;
                else vm_stack[vm_sp-1] = vm_heap[vm_stack[vm_sp-1][svx_pkg::HA_W-1:0]];
            end
            svx_pkg::OP_LABEL: ;
            svx_pkg::OP_CALL: begin
                if (vm_rp >= svx_pkg::CALL_DEPTH) o.status = svx_pkg::ST_OVER;
                else begin
                    vm_calls[vm_rp] = x.fall;
                    vm_rp++;
                    o.status  = svx_pkg::ST_JUMP;
                    o.next_pc = x.tgt;
                end
            end
            svx_pkg::OP_JUMP: begin
                o.status  = svx_pkg::ST_JUMP;
                o.next_pc = x.tgt;
            end
            svx_pkg::OP_JZ, svx_pkg::OP_JNEG: begin
                if (vm_sp < 1) o.status = svx_pkg::ST_UNDER;
                else begin
                    a = vm_stack[vm_sp-1];
                    vm_sp--;
                    if ((x.op == svx_pkg::OP_JZ && a == 32'd0) ||
                        (x.op == svx_pkg::OP_JNEG && a[31])) begin
                        o.status  = svx_pkg::ST_JUMP;
                        o.next_pc = x.tgt;
                    end
                end
            end
            svx_pkg::OP_RET: begin
                if (vm_rp < 1) o.status = svx_pkg::ST_UNDER;
                else begin
                    vm_rp--;
                    o.next_pc = vm_calls[vm_rp];
                    o.status  = svx_pkg::ST_JUMP;
                end
            end
            svx_pkg::OP_END: begin
                o.status   = svx_pkg::ST_EXIT;
                vm_running = 1'b0;
            end
            svx_pkg::OP_OUTC, svx_pkg::OP_OUTN: begin
                if (vm_sp < 1) o.status = svx_pkg::ST_UNDER;
                else begin
                    o.value = vm_stack[vm_sp-1];
                    vm_sp--;
                    o.kind = (x.op == svx_pkg::OP_OUTC) ? 2'd1 : 2'd2;
                end
            end
            svx_pkg::OP_READC, svx_pkg::OP_READN: begin
                if (vm_sp < 1) o.status = svx_pkg::ST_UNDER;
                else if (!heap_addr_ok(vm_stack[vm_sp-1])) o.status = svx_pkg::ST_HEAP;
                else begin
                    vm_heap[vm_stack[vm_sp-1][svx_pkg::HA_W-1:0]] = x.rdv;
                    vm_sp--;
                end
            end
            default: ;
        endcase
        if (o.status >= svx_pkg::ST_UNDER && o.status <= svx_pkg::ST_OVER) vm_running = 1'b0;
        return o;
    endfunction

    // whether an instruction would fault in the current state
    function automatic bit would_fault(t_instr x);
        case (x.op)
            svx_pkg::OP_PUSH:  return vm_sp >= svx_pkg::STACK_DEPTH;
            svx_pkg::OP_DUP:   return vm_sp < 1 || vm_sp >= svx_pkg::STACK_DEPTH;
            svx_pkg::OP_COPY:
                return x.imm[31] || x.imm >= vm_sp || vm_sp >= svx_pkg::STACK_DEPTH;
            svx_pkg::OP_SWAP:  return vm_sp < 2;
            svx_pkg::OP_SLIDE: return x.imm[31] || x.imm >= vm_sp;
            svx_pkg::OP_ADD, svx_pkg::OP_SUB, svx_pkg::OP_MUL: return vm_sp < 2;
            svx_pkg::OP_DIV, svx_pkg::OP_MOD:
                return vm_sp < 2 || vm_stack[vm_sp-1] == 32'd0;
            svx_pkg::OP_STORE: return vm_sp < 2 || !heap_addr_ok(vm_stack[vm_sp-2]);
            svx_pkg::OP_RETR, svx_pkg::OP_READC, svx_pkg::OP_READN:
                return vm_sp < 1 || !heap_addr_ok(vm_stack[vm_sp-1]);
            svx_pkg::OP_CALL:  return vm_rp >= svx_pkg::CALL_DEPTH;
            svx_pkg::OP_RET:   return vm_rp < 1;
            svx_pkg::OP_END:   return 1'b1;
            svx_pkg::OP_DROP, svx_pkg::OP_JZ, svx_pkg::OP_JNEG,
            svx_pkg::OP_OUTC, svx_pkg::OP_OUTN: return vm_sp < 1;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return 32'($urandom_range(0, svx_pkg::HEAP_WORDS - 1));
        if (sel < 7) return 32'($urandom_range(0, 10)) - 32'd5;
        if (sel == 7) begin
            // zero, minus one and the extremes of the signed range
            case ($urandom_range(0, 3))
                0: return 32'h00000000;
                1: return 32'hffffffff;
                2: return 32'h80000000;
                default: return 32'h7fffffff;
            endcase
        end
        return $urandom;
    endfunction

    // random instruction that keeps the machine running
    function automatic t_instr pick_instr();
        t_instr x;
        x.tgt  = 16'($urandom);
        x.fall = 16'($urandom);
        x.rdv  = $urandom;
        do begin
            if (vm_sp < 3 && $urandom_range(0, 1)) x.op = svx_pkg::OP_PUSH;
            else if (vm_sp > 200) x.op = svx_pkg::OP_DROP;
            else if (vm_rp > 40 && $urandom_range(0, 3) == 0) x.op = svx_pkg::OP_RET;
            else if ($urandom_range(0, 29) == 0) x.op = 5'($urandom_range(24, 31));
            else x.op = 5'($urandom_range(0, 23));
            if (x.op == svx_pkg::OP_PUSH) x.imm = rand_value();
            else if ((x.op == svx_pkg::OP_COPY || x.op == svx_pkg::OP_SLIDE) && vm_sp > 0 &&
                     $urandom_range(0, 7) != 0)
                x.imm = 32'($urandom_range(0, vm_sp - 1));
            else x.imm = $urandom;
        end while (would_fault(x));
        return x;
    endfunction

    // drive one instruction word and record its expected result on acceptance
    task automatic send_instr(t_instr x);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 104'({$urandom, $urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, x.rdv, x.fall, x.tgt, x.imm, x.op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(execute_instr(x));
        words_sent++;
    endtask

    task automatic send_op(logic [4:0] op, logic [31:0] imm);
        t_instr x;
        x.op   = op;
        x.imm  = imm;
        x.tgt  = 16'($urandom);
        x.fall = 16'($urandom);
        x.rdv  = $urandom;
        send_instr(x);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 words_checked, field, got, want);
        error_count++;
    endtask

    // result word check and receiver stalls
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $display("unexpected result word %h", m_axis_tdata);
                error_count++;
            end else begin
                w = pending_q.pop_front();
                if (m_axis_tdata[2:0] !== w.status)
                    report_mismatch("status", 32'(m_axis_tdata[2:0]), 32'(w.status));
                if (m_axis_tdata[18:3] !== w.next_pc)
                    report_mismatch("next_pc", 32'(m_axis_tdata[18:3]), 32'(w.next_pc));
                if (m_axis_tdata[20:19] !== w.kind)
                    report_mismatch("out_kind", 32'(m_axis_tdata[20:19]), 32'(w.kind));
                if (m_axis_tdata[52:21] !== w.value)
                    report_mismatch("out_value", m_axis_tdata[52:21], w.value);
            end
            words_checked++;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // every operation but drop and end, with edge operands, machine stays running
    task automatic test_directed_ops();
        send_op(svx_pkg::OP_PUSH, 32'h7fffffff);
        send_op(svx_pkg::OP_PUSH, 32'h80000000);
        send_op(svx_pkg::OP_ADD, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'h80000000);
        send_op(svx_pkg::OP_PUSH, 32'hffffffff);
        send_op(svx_pkg::OP_DIV, 32'd0);          // most negative over minus one wraps
        send_op(svx_pkg::OP_PUSH, 32'h80000000);
        send_op(svx_pkg::OP_PUSH, 32'hffffffff);
        send_op(svx_pkg::OP_MOD, 32'd0);          // remainder zero
        send_op(svx_pkg::OP_PUSH, 32'hfffffff9);
        send_op(svx_pkg::OP_PUSH, 32'd2);
        send_op(svx_pkg::OP_MOD, 32'd0);          // remainder takes dividend sign
        send_op(svx_pkg::OP_DUP, 32'd0);
        send_op(svx_pkg::OP_COPY, 32'd3);
        send_op(svx_pkg::OP_SWAP, 32'd0);
        send_op(svx_pkg::OP_SUB, 32'd0);
        send_op(svx_pkg::OP_MUL, 32'd0);
        send_op(svx_pkg::OP_SLIDE, 32'd2);
        send_op(svx_pkg::OP_PUSH, 32'(svx_pkg::HEAP_WORDS - 1));
        send_op(svx_pkg::OP_PUSH, 32'hdeadbeef);
        send_op(svx_pkg::OP_STORE, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'(svx_pkg::HEAP_WORDS - 1));
        send_op(svx_pkg::OP_RETR, 32'd0);
        send_op(svx_pkg::OP_OUTN, 32'd0);
        send_op(svx_pkg::OP_LABEL, 32'd0);
        send_op(svx_pkg::OP_CALL, 32'd0);
        send_op(svx_pkg::OP_JUMP, 32'd0);
        send_op(svx_pkg::OP_RET, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'd0);
        send_op(svx_pkg::OP_JZ, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'hffffffff);
        send_op(svx_pkg::OP_JNEG, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'd0);
        send_op(svx_pkg::OP_READC, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'd65);
        send_op(svx_pkg::OP_OUTC, 32'd0);
        send_op(svx_pkg::OP_PUSH, 32'd1);
        send_op(svx_pkg::OP_READN, 32'd0);
        send_op(5'd31, 32'd0);                    // unused code acts as no operation
    endtask

    task automatic test_random_program(int n, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n) send_instr(pick_instr());
    endtask

    // one fault or an end stops the machine, then everything reports halted
    task automatic test_stop_and_halt();
        case ($urandom_range(0, 4))
            0: send_op(svx_pkg::OP_SLIDE, 32'hffffffff);
            1: begin
                send_op(svx_pkg::OP_PUSH, 32'hffffffff);
                send_op(svx_pkg::OP_RETR, 32'd0);
            end
            2: begin
                send_op(svx_pkg::OP_PUSH, $urandom);
                send_op(svx_pkg::OP_PUSH, 32'd0);
                send_op(svx_pkg::OP_DIV, 32'd0);
            end
            3: begin
                while (vm_sp < svx_pkg::STACK_DEPTH) send_op(svx_pkg::OP_PUSH, $urandom);
                send_op(svx_pkg::OP_PUSH, 32'd1);
            end
            default: send_op(svx_pkg::OP_END, 32'd0);
        endcase
        repeat (10) send_op(5'($urandom), $urandom);
    endtask

    initial begin
        for (int i = 0; i < svx_pkg::HEAP_WORDS; i++) vm_heap[i] = 32'd0;
        vm_sp = 0;
        vm_rp = 0;
        vm_running         = 1'b1;
        error_count        = 0;
        words_sent         = 0;
        words_checked      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_random_program(370, 0, 0);
        test_random_program(370, 49, 0);
        test_random_program(370, 0, 49);
        test_random_program(370, 38, 38);
        test_stop_and_halt();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("%0d instruction words sent, %0d result words checked, %0d errors",
                 words_sent, words_checked, error_count);
        $display("covered all ops, divide corners, call nesting, heap, stop and halted state");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: stack_vm_execute_unit_top.f
+incdir+hw/rtl
hw/rtl/svx_pkg.sv
hw/rtl/svx_divider.sv
hw/rtl/svx_datapath.sv
hw/rtl/svx_ctrl.sv
hw/rtl/stack_vm_execute_unit_top.sv
hw/rtl/svx_checker.sv
bench/tb_stack_vm_execute_unit_top.sv
